// ===== design/wavp_pkg.sv =====
// ----------------------------------------------------------------------------
// wavp_pkg
// Shared types and constants for the WAV header parser and PCM converter.
// ----------------------------------------------------------------------------
package wavp_pkg;

	localparam logic [31:0] MAGIC_RIFF = 32'h5249_4646;
	localparam logic [31:0] MAGIC_WAVE = 32'h5741_5645;
	localparam logic [31:0] MAGIC_FMT  = 32'h666D_7420;
	localparam logic [31:0] MAGIC_DATA = 32'h6461_7461;
	localparam logic [31:0] FMT_BODY_LEN = 32'd16;
	localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;
	localparam logic [31:0] FILE_LENGTH_RESET = 32'hFFFF_FFFF;

	localparam logic [1:0] KIND_FORMAT = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [2:0] ERR_NOT_RIFF    = 3'd0;
	localparam logic [2:0] ERR_NOT_WAVE    = 3'd1;
	localparam logic [2:0] ERR_NO_FMT      = 3'd2;
	localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
	localparam logic [2:0] ERR_SHORT_FMT   = 3'd4;
	localparam logic [2:0] ERR_NO_DATA     = 3'd5;

	typedef enum logic [11:0] {
		PH_RIFF    = 12'h001,
		PH_RSIZE   = 12'h002,
		PH_WAVE    = 12'h004,
		PH_FMTID   = 12'h008,
		PH_FMTSIZE = 12'h010,
		PH_FMTBODY = 12'h020,
		PH_FMTSKIP = 12'h040,
		PH_CKID    = 12'h080,
		PH_CKSIZE  = 12'h100,
		PH_CKSKIP  = 12'h200,
		PH_DATA    = 12'h400,
		PH_DONE    = 12'h800
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  code;
		logic [15:0] word;
		logic [31:0] rate;
		logic [1:0]  chans;
		logic [4:0]  bits;
		logic [31:0] len;
	} result_t;

endpackage

// ===== design/wavp_parse.sv =====
// ----------------------------------------------------------------------------
// wavp_parse
// Per-byte parser state and next-state logic; builds the result of one byte.
// ----------------------------------------------------------------------------
module wavp_parse
	import wavp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        fire,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	output logic        emit,
	output result_t     res
);

	logic [31:0] file_length_q;
	phase_t      phase_q;
	logic [31:0] field_q;
	logic [3:0]  bif_q;
	logic [31:0] name_q;
	logic [31:0] skip_q;
	logic [31:0] pos_q;
	logic [31:0] rem_q;
	logic [31:0] rate_q;
	logic [1:0]  chans_q;
	logic [4:0]  bits_q;
	logic        fmt_bad_q;
	logic        held_vld_q;
	logic [7:0]  held_q;

	phase_t      e_phase, nx_phase;
	logic [31:0] e_field, nx_field;
	logic [3:0]  e_bif, nx_bif, bif_inc;
	logic [31:0] e_name, nx_name, name_sh;
	logic [31:0] e_skip, nx_skip;
	logic [31:0] e_pos, nx_pos;
	logic [31:0] e_rem, nx_rem, rem_dec;
	logic [31:0] e_rate, nx_rate;
	logic [1:0]  e_chans, nx_chans;
	logic [4:0]  e_bits, nx_bits;
	logic        e_bad, nx_bad;
	logic        e_hvld, nx_hvld;
	logic [7:0]  e_held, nx_held;
	logic        word_done;
	logic [31:0] size_field, body_field, avail, clamp;
	logic [2:0]  off;
	logic        rej;
	logic [2:0]  rej_code;

	function automatic logic name_q_is_data(input logic [31:0] name);
		return name == MAGIC_DATA;
	endfunction

	always_comb begin
		e_phase = first_byte ? PH_RIFF : phase_q;
		e_field = first_byte ? '0 : field_q;
		e_bif   = first_byte ? '0 : bif_q;
		e_name  = first_byte ? '0 : name_q;
		e_skip  = first_byte ? '0 : skip_q;
		e_pos   = first_byte ? '0 : pos_q;
		e_rem   = first_byte ? '0 : rem_q;
		e_rate  = first_byte ? '0 : rate_q;
		e_chans = first_byte ? '0 : chans_q;
		e_bits  = first_byte ? '0 : bits_q;
		e_bad   = first_byte ? 1'b0 : fmt_bad_q;
		e_hvld  = first_byte ? 1'b0 : held_vld_q;
		e_held  = first_byte ? '0 : held_q;

		nx_phase = e_phase;
		nx_field = e_field;
		nx_bif   = e_bif;
		nx_name  = e_name;
		nx_skip  = e_skip;
		nx_rem   = e_rem;
		nx_rate  = e_rate;
		nx_chans = e_chans;
		nx_bits  = e_bits;
		nx_bad   = e_bad;
		nx_hvld  = e_hvld;
		nx_held  = e_held;
		nx_pos   = e_pos;
		if (e_phase != PH_DONE && e_pos != 32'hFFFF_FFFF) begin
			nx_pos = e_pos + 32'd1;
		end

		bif_inc   = e_bif + 4'd1;
		word_done = (bif_inc >= 4'd4);
		name_sh   = {e_name[23:0], data_byte};
		size_field = ((e_bif == 4'd0) ? 32'd0 : e_field)
			| ({24'd0, data_byte} << {e_bif[1:0], 3'b000});

		off = 3'd4;
		case (e_bif)
			4'd0, 4'd1: off = e_bif[2:0];
			4'd2, 4'd3: off = 3'(e_bif - 4'd2);
			4'd4, 4'd5, 4'd6, 4'd7: off = 3'(e_bif - 4'd4);
			4'd14, 4'd15: off = 3'(e_bif - 4'd14);
			default: off = 3'd4;
		endcase
		body_field = (e_bif == 4'd0 || e_bif == 4'd2 || e_bif == 4'd4 || e_bif == 4'd14)
			? 32'd0 : e_field;
		if (off < 3'd4) begin
			body_field = body_field | ({24'd0, data_byte} << {off[1:0], 3'b000});
		end

		avail = (file_length_q > nx_pos) ? (file_length_q - nx_pos) : 32'd0;
		clamp = (size_field > avail) ? avail : size_field;
		rem_dec = (e_rem != 32'd0) ? (e_rem - 32'd1) : 32'd0;

		rej      = 1'b0;
		rej_code = ERR_NOT_RIFF;
		emit     = 1'b0;
		res      = '0;

		case (e_phase)
			PH_RIFF, PH_WAVE, PH_FMTID, PH_CKID: begin
				nx_name = name_sh;
				nx_bif  = word_done ? 4'd0 : bif_inc;
				if (word_done) begin
					case (e_phase)
						PH_RIFF: begin
							if (name_sh != MAGIC_RIFF) begin
								rej = 1'b1;
								rej_code = ERR_NOT_RIFF;
							end else begin
								nx_phase = PH_RSIZE;
							end
						end
						PH_WAVE: begin
							if (name_sh != MAGIC_WAVE) begin
								rej = 1'b1;
								rej_code = ERR_NOT_WAVE;
							end else begin
								nx_phase = PH_FMTID;
							end
						end
						PH_FMTID: begin
							if (name_sh != MAGIC_FMT) begin
								rej = 1'b1;
								rej_code = ERR_NO_FMT;
							end else begin
								nx_phase = PH_FMTSIZE;
							end
						end
						default: nx_phase = PH_CKSIZE;
					endcase
				end
			end
			PH_RSIZE, PH_FMTSIZE, PH_CKSIZE: begin
				nx_field = size_field;
				nx_bif   = word_done ? 4'd0 : bif_inc;
				if (word_done) begin
					case (e_phase)
						PH_RSIZE: nx_phase = PH_WAVE;
						PH_FMTSIZE: begin
							if (size_field < FMT_BODY_LEN) begin
								rej = 1'b1;
								rej_code = ERR_SHORT_FMT;
							end else begin
								nx_skip  = size_field - FMT_BODY_LEN;
								nx_rate  = '0;
								nx_chans = '0;
								nx_bits  = '0;
								nx_bad   = 1'b0;
								nx_phase = PH_FMTBODY;
							end
						end
						default: begin
							if (name_q_is_data(e_name)) begin
								if (clamp == 32'd0) begin
									rej = 1'b1;
									rej_code = ERR_NO_DATA;
								end else begin
									emit      = 1'b1;
									res.kind  = KIND_FORMAT;
									res.rate  = e_rate;
									res.chans = e_chans;
									res.bits  = e_bits;
									res.len   = clamp;
									nx_rem    = clamp;
									nx_hvld   = 1'b0;
									nx_phase  = PH_DATA;
								end
							end else begin
								nx_skip  = size_field;
								nx_phase = (size_field != 32'd0) ? PH_CKSKIP : PH_CKID;
							end
						end
					endcase
				end
			end
			PH_FMTBODY: begin
				nx_field = body_field;
				nx_bif   = bif_inc;
				if (e_bif == 4'd1 && body_field != 32'd1) begin
					nx_bad = 1'b1;
				end
				if (e_bif == 4'd3) begin
					if (body_field > 32'd2) begin
						nx_bad = 1'b1;
					end else begin
						nx_chans = body_field[1:0];
					end
				end
				if (e_bif == 4'd7) begin
					nx_rate = body_field;
				end
				if (e_bif == 4'd15) begin
					nx_bif = 4'd0;
					if (body_field != 32'd8 && body_field != 32'd16) begin
						rej = 1'b1;
						rej_code = ERR_UNSUPPORTED;
					end else begin
						nx_bits = body_field[4:0];
						if (nx_bad) begin
							rej = 1'b1;
							rej_code = ERR_UNSUPPORTED;
						end else begin
							nx_phase = (e_skip != 32'd0) ? PH_FMTSKIP : PH_CKID;
						end
					end
				end
			end
			PH_FMTSKIP, PH_CKSKIP: begin
				nx_skip = (e_skip != 32'd0) ? (e_skip - 32'd1) : 32'd0;
				if (nx_skip == 32'd0) begin
					nx_phase = PH_CKID;
				end
			end
			PH_DATA: begin
				if (e_bits == 5'd16) begin
					if (e_hvld) begin
						emit     = 1'b1;
						res.kind = KIND_SAMPLE;
						res.word = (({data_byte, 8'd0}) & HIGH_BYTE_MASK) | {8'd0, e_held};
						nx_hvld  = 1'b0;
					end else begin
						nx_hvld = 1'b1;
						nx_held = data_byte;
					end
				end else begin
					emit     = 1'b1;
					res.kind = KIND_SAMPLE;
					res.word = ({data_byte ^ 8'h80, 8'd0}) & HIGH_BYTE_MASK;
				end
				nx_rem = rem_dec;
				if (rem_dec == 32'd0) begin
					nx_hvld  = 1'b0;
					nx_phase = PH_DONE;
				end
			end
			default: begin
				nx_phase = e_phase;
			end
		endcase

		// truncated header: file ends before the data chunk is reached
		if (!rej && !emit && nx_phase != PH_DATA && nx_phase != PH_DONE
				&& nx_pos >= file_length_q) begin
			rej = 1'b1;
			case (nx_phase)
				PH_RIFF, PH_RSIZE:    rej_code = ERR_NOT_RIFF;
				PH_WAVE:              rej_code = ERR_NOT_WAVE;
				PH_FMTID, PH_FMTSIZE: rej_code = ERR_NO_FMT;
				PH_FMTBODY:           rej_code = ERR_SHORT_FMT;
				default:              rej_code = ERR_NO_DATA;
			endcase
		end

		if (rej) begin
			emit     = 1'b1;
			res      = '0;
			res.kind = KIND_REJECT;
			res.code = rej_code;
			nx_phase = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= FILE_LENGTH_RESET;
		end else if (cfg_we) begin
			file_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF;
			field_q    <= '0;
			bif_q      <= '0;
			name_q     <= '0;
			skip_q     <= '0;
			pos_q      <= '0;
			rem_q      <= '0;
			rate_q     <= '0;
			chans_q    <= '0;
			bits_q     <= '0;
			fmt_bad_q  <= 1'b0;
			held_vld_q <= 1'b0;
			held_q     <= '0;
		end else if (fire) begin
			phase_q    <= nx_phase;
			field_q    <= nx_field;
			bif_q      <= nx_bif;
			name_q     <= nx_name;
			skip_q     <= nx_skip;
			pos_q      <= nx_pos;
			rem_q      <= nx_rem;
			rate_q     <= nx_rate;
			chans_q    <= nx_chans;
			bits_q     <= nx_bits;
			fmt_bad_q  <= nx_bad;
			held_vld_q <= nx_hvld;
			held_q     <= nx_held;
		end
	end

endmodule

// ===== design/wavp_out_reg.sv =====
// ----------------------------------------------------------------------------
// wavp_out_reg
// Result register: holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module wavp_out_reg
	import wavp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    stall,
	output logic    free,
	output logic    valid,
	output result_t res_q
);

	logic valid_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== design/wav_header_parse_and_pcm_convert.sv =====
// ----------------------------------------------------------------------------
// wav_header_parse_and_pcm_convert
// WAV header parser with PCM to 16-bit big-endian sample conversion.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle. A byte is registered on transfer and processed
// by the parser in the following cycle; any result it causes is loaded into the
// result register once that register is free, and result valid is registered.
// The parser sustains one byte per clock; input stalls only while a byte that
// produces a result waits for a stalled result register.
// Write file_length while idle; first_byte restarts parsing for a new file.
module wav_header_parse_and_pcm_convert
	import wavp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  result_kind,
	output logic [2:0]  error_code,
	output logic [15:0] sample_word,
	output logic [31:0] sample_hz,
	output logic [1:0]  channel_count,
	output logic [4:0]  sample_bits,
	output logic [31:0] data_length
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       emit;
	logic       out_free;
	logic       fire_s1;
	result_t    res_s1;
	result_t    res_q;

	assign fire_s1    = valid_s1 && (!emit || out_free);
	assign byte_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	wavp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fire       (fire_s1),
		.data_byte  (byte_s1),
		.first_byte (first_s1),
		.emit       (emit),
		.res        (res_s1)
	);

	wavp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire_s1 && emit),
		.res_in (res_s1),
		.stall  (result_stall),
		.free   (out_free),
		.valid  (result_valid),
		.res_q  (res_q)
	);

	assign result_kind   = res_q.kind;
	assign error_code    = res_q.code;
	assign sample_word   = res_q.word;
	assign sample_hz     = res_q.rate;
	assign channel_count = res_q.chans;
	assign sample_bits   = res_q.bits;
	assign data_length   = res_q.len;

`ifndef SYNTH
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && emit && result_valid && result_stall) |-> !fire_s1)
		else $error("result register overwritten while stalled");

	a_code_only_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind != KIND_REJECT) |-> (error_code == ERR_NOT_RIFF))
		else $error("error code set on non-reject result");

	a_format_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == KIND_FORMAT) |-> (data_length != 32'd0))
		else $error("format result with empty data");
`endif

endmodule

// ===== bench/wav_header_parse_and_pcm_convert_tb.sv =====
// ----------------------------------------------------------------------------
// wav_header_parse_and_pcm_convert_tb
// Streams WAV files, well-formed, damaged and cut short, into the parser under
// several file_length settings and matches every format, sample and rejection
// result against a cycle-free model of the parser kept in a scoreboard.
// ----------------------------------------------------------------------------
module wav_header_parse_and_pcm_convert_tb;
	import wavp_pkg::*;

	localparam int ITEM_TARGET = 1350;
	localparam int HOLD_CYCLES = 200;

	typedef logic [7:0] file_bytes_t[$];

	class wav_scoreboard;
		result_t     results_due[$];
		int          fails;
		int          sent_items;
		logic [31:0] file_len;
		phase_t      phase;
		logic [31:0] shift_reg;
		int unsigned field_idx;
		logic [31:0] name_reg;
		logic [31:0] skip_left;
		logic [31:0] pos;
		logic [31:0] data_left;
		logic [31:0] fmt_rate;
		logic [1:0]  fmt_chans;
		logic [4:0]  fmt_bits;
		logic        fmt_bad;
		logic        held_ok;
		logic [7:0]  held_val;

		function new();
			fails = 0;
			sent_items = 0;
			file_len = FILE_LENGTH_RESET;
			restart();
		endfunction

		function void set_file_length(logic [31:0] v);
			file_len = v;
		endfunction

		function void restart();
			phase = PH_RIFF;
			shift_reg = '0;
			field_idx = 0;
			name_reg = '0;
			skip_left = '0;
			pos = '0;
			data_left = '0;
			fmt_rate = '0;
			fmt_chans = '0;
			fmt_bits = '0;
			fmt_bad = 1'b0;
			held_ok = 1'b0;
			held_val = '0;
		endfunction

		function void push_reject(logic [2:0] code);
			result_t r;
			r = '0;
			r.kind = KIND_REJECT;
			r.code = code;
			results_due.push_back(r);
			phase = PH_DONE;
		endfunction

		function void push_sample(logic [15:0] w);
			result_t r;
			r = '0;
			r.kind = KIND_SAMPLE;
			r.word = w;
			results_due.push_back(r);
		endfunction

		function bit take_magic(logic [7:0] b);
			name_reg = {name_reg[23:0], b};
			field_idx++;
			if (field_idx >= 4) begin
				field_idx = 0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit take_size(logic [7:0] b);
			if (field_idx == 0)
				shift_reg = '0;
			shift_reg |= 32'(b) << (8 * (field_idx & 3));
			field_idx++;
			if (field_idx >= 4) begin
				field_idx = 0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit fmt_body(logic [7:0] b);
			int unsigned k;
			int unsigned off;
			k = field_idx & 15;
			off = 4;
			if (k == 0 || k == 2 || k == 4 || k == 14)
				shift_reg = '0;
			if (k < 2)
				off = k;
			else if (k < 4)
				off = k - 2;
			else if (k < 8)
				off = k - 4;
			else if (k >= 14)
				off = k - 14;
			if (off < 4)
				shift_reg |= 32'(b) << (8 * off);
			if (k == 1 && shift_reg != 32'd1)
				fmt_bad = 1'b1;
			if (k == 3) begin
				if (shift_reg > 32'd2)
					fmt_bad = 1'b1;
				else
					fmt_chans = shift_reg[1:0];
			end
			if (k == 7)
				fmt_rate = shift_reg;
			field_idx = k + 1;
			if (k == 15) begin
				if (shift_reg != 32'd8 && shift_reg != 32'd16)
					fmt_bad = 1'b1;
				else
					fmt_bits = shift_reg[4:0];
				field_idx = 0;
				if (fmt_bad) begin
					push_reject(ERR_UNSUPPORTED);
					return 1'b1;
				end
				phase = (skip_left != 0) ? PH_FMTSKIP : PH_CKID;
			end
			return 1'b0;
		endfunction

		function bit chunk_found();
			logic [31:0] size;
			logic [31:0] avail;
			result_t     r;
			size = shift_reg;
			avail = (file_len > pos) ? file_len - pos : 32'd0;
			if (name_reg != MAGIC_DATA) begin
				skip_left = size;
				phase = (size != 0) ? PH_CKSKIP : PH_CKID;
				return 1'b0;
			end
			if (size > avail)
				size = avail;
			if (size == 0) begin
				push_reject(ERR_NO_DATA);
				return 1'b1;
			end
			r = '0;
			r.kind = KIND_FORMAT;
			r.rate = fmt_rate;
			r.chans = fmt_chans;
			r.bits = fmt_bits;
			r.len = size;
			results_due.push_back(r);
			data_left = size;
			held_ok = 1'b0;
			phase = PH_DATA;
			return 1'b1;
		endfunction

		function void data_step(logic [7:0] b);
			if (fmt_bits == 5'd16) begin
				if (held_ok) begin
					push_sample({b, held_val});
					held_ok = 1'b0;
				end else begin
					held_ok = 1'b1;
					held_val = b;
				end
			end else begin
				push_sample({b ^ 8'h80, 8'h00});
			end
			if (data_left != 0)
				data_left--;
			if (data_left == 0) begin
				held_ok = 1'b0;
				phase = PH_DONE;
			end
		endfunction

		function logic [2:0] cut_code(phase_t p);
			case (p)
				PH_RIFF, PH_RSIZE:   return ERR_NOT_RIFF;
				PH_WAVE:             return ERR_NOT_WAVE;
				PH_FMTID, PH_FMTSIZE: return ERR_NO_FMT;
				PH_FMTBODY:          return ERR_SHORT_FMT;
				default:             return ERR_NO_DATA;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic first);
			bit emitted;
			emitted = 1'b0;
			sent_items++;
			if (first)
				restart();
			if (phase == PH_DONE)
				return;
			if (pos != 32'hFFFF_FFFF)
				pos++;
			case (phase)
				PH_RIFF: begin
					if (take_magic(b)) begin
						if (name_reg != MAGIC_RIFF) begin
							push_reject(ERR_NOT_RIFF);
							return;
						end
						phase = PH_RSIZE;
					end
				end
				PH_RSIZE: begin
					if (take_size(b))
						phase = PH_WAVE;
				end
				PH_WAVE: begin
					if (take_magic(b)) begin
						if (name_reg != MAGIC_WAVE) begin
							push_reject(ERR_NOT_WAVE);
							return;
						end
						phase = PH_FMTID;
					end
				end
				PH_FMTID: begin
					if (take_magic(b)) begin
						if (name_reg != MAGIC_FMT) begin
							push_reject(ERR_NO_FMT);
							return;
						end
						phase = PH_FMTSIZE;
					end
				end
				PH_FMTSIZE: begin
					if (take_size(b)) begin
						if (shift_reg < FMT_BODY_LEN) begin
							push_reject(ERR_SHORT_FMT);
							return;
						end
						skip_left = shift_reg - FMT_BODY_LEN;
						fmt_rate = '0;
						fmt_chans = '0;
						fmt_bits = '0;
						fmt_bad = 1'b0;
						phase = PH_FMTBODY;
					end
				end
				PH_FMTBODY: emitted = fmt_body(b);
				PH_FMTSKIP, PH_CKSKIP: begin
					if (skip_left != 0)
						skip_left--;
					if (skip_left == 0)
						phase = PH_CKID;
				end
				PH_CKID: begin
					if (take_magic(b))
						phase = PH_CKSIZE;
				end
				PH_CKSIZE: begin
					if (take_size(b))
						emitted = chunk_found();
				end
				PH_DATA: begin
					data_step(b);
					return;
				end
				default: ;
			endcase
			if (!emitted && phase != PH_DATA && phase != PH_DONE && pos >= file_len)
				push_reject(cut_code(phase));
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0h, actual %0h", field, want, seen);
				fails++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (results_due.size() == 0) begin
				$error("result_kind: expected none, actual %0h", got.kind);
				fails++;
				return;
			end
			want = results_due.pop_front();
			compare("result_kind", 32'(want.kind), 32'(got.kind));
			compare("error_code", 32'(want.code), 32'(got.code));
			compare("sample_word", 32'(want.word), 32'(got.word));
			compare("sample_hz", want.rate, got.rate);
			compare("channel_count", 32'(want.chans), 32'(got.chans));
			compare("sample_bits", 32'(want.bits), 32'(got.bits));
			compare("data_length", want.len, got.len);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  result_kind;
	logic [2:0]  error_code;
	logic [15:0] sample_word;
	logic [31:0] sample_hz;
	logic [1:0]  channel_count;
	logic [4:0]  sample_bits;
	logic [31:0] data_length;

	logic calm;
	logic hold_req;

	wav_scoreboard sb = new();

	wav_header_parse_and_pcm_convert u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_kind   (result_kind),
		.error_code    (error_code),
		.sample_word   (sample_word),
		.sample_hz     (sample_hz),
		.channel_count (channel_count),
		.sample_bits   (sample_bits),
		.data_length   (data_length)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result({result_kind, error_code, sample_word, sample_hz,
					channel_count, sample_bits, data_length});
			if (byte_valid && !byte_stall)
				sb.note_byte(data_byte, first_byte);
		end
	end

	initial begin
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (hold_req && !hold_done) begin
				stall_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 8);
			result_stall <= (stall_left > 0);
		end
	end

	function automatic void put_le(ref file_bytes_t fb, input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			fb.push_back(v[8*i +: 8]);
	endfunction

	function automatic void put_magic(ref file_bytes_t fb, input logic [31:0] m);
		for (int i = 3; i >= 0; i--)
			fb.push_back(m[8*i +: 8]);
	endfunction

	function automatic void build_header(ref file_bytes_t fb, input logic [31:0] fsize,
			input logic [31:0] tag, input logic [31:0] chans, input logic [31:0] rate,
			input logic [31:0] bits, input int nchunks, input bit with_data,
			input logic [31:0] dsize);
		int n;
		put_magic(fb, MAGIC_RIFF);
		put_le(fb, $urandom, 4);
		put_magic(fb, MAGIC_WAVE);
		put_magic(fb, MAGIC_FMT);
		put_le(fb, fsize, 4);
		put_le(fb, tag, 2);
		put_le(fb, chans, 2);
		put_le(fb, rate, 4);
		put_le(fb, $urandom, 4);
		put_le(fb, $urandom, 2);
		put_le(fb, bits, 2);
		if (fsize > 16)
			repeat (fsize - 16) fb.push_back(8'($urandom));
		repeat (nchunks) begin
			n = $urandom_range(0, 5);
			put_magic(fb, $urandom);
			put_le(fb, n, 4);
			repeat (n) fb.push_back(8'($urandom));
		end
		if (with_data) begin
			put_magic(fb, MAGIC_DATA);
			put_le(fb, dsize, 4);
		end
	endfunction

	function automatic void build_random(ref file_bytes_t fb);
		logic [31:0] fsize;
		logic [31:0] tag;
		logic [31:0] chans;
		logic [31:0] bits;
		logic [31:0] dsize;
		int          pick;
		int          nd;
		int          at;
		fb.delete();
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 10)) fb.push_back(8'($urandom));
			return;
		end
		pick = $urandom_range(0, 19);
		fsize = (pick < 2) ? $urandom_range(0, 15) : (pick < 5) ? $urandom_range(17, 22) : 16;
		tag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : 1;
		chans = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2);
		pick = $urandom_range(0, 19);
		bits = (pick < 9) ? 8 : (pick < 18) ? 16 : $urandom_range(0, 65535);
		pick = $urandom_range(0, 19);
		dsize = (pick < 2) ? 0 : (pick < 14) ? $urandom_range(1, 24) :
			(pick < 17) ? $urandom_range(25, 48) : $urandom;
		build_header(fb, fsize, tag, chans, $urandom, bits, $urandom_range(0, 2),
			$urandom_range(0, 9) != 0, dsize);
		if (dsize <= 48)
			nd = int'(dsize) + int'($urandom_range(0, 6)) - 3;
		else
			nd = $urandom_range(0, 30);
		if (nd < 0)
			nd = 0;
		repeat (nd) fb.push_back(8'($urandom));
		if ($urandom_range(0, 9) == 0) begin
			at = $urandom_range(0, 43);
			if (at < fb.size())
				fb[at] = fb[at] ^ 8'($urandom_range(1, 255));
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic first);
		if (!calm && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		first_byte <= first;
		do @(posedge clk); while (byte_stall);
		@(negedge clk);
	endtask

	task automatic send_file(input file_bytes_t fb);
		foreach (fb[i])
			send_byte(fb[i], i == 0);
	endtask

	task automatic load_file_length(input logic [31:0] v);
		byte_valid <= 1'b0;
		while (sb.results_due.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_file_length(v);
	endtask

	initial begin
		file_bytes_t fb;
		logic [31:0] flen;
		int          phase_no;
		int          pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		byte_valid = 1'b0;
		data_byte = '0;
		first_byte = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		fb = {8'h52, 8'h49, 8'h46, 8'h58};
		send_file(fb);
		fb.delete();
		build_header(fb, 16, 1, 1, 32'hFFFF_FFFF, 16, 0, 1'b1, 3);
		fb.push_back(8'h00);
		fb.push_back(8'hFF);
		fb.push_back(8'h80);
		send_file(fb);

		phase_no = 0;
		while (sb.sent_items < ITEM_TARGET) begin
			if (phase_no == 0)
				flen = '0;
			else if (phase_no == 1)
				flen = FILE_LENGTH_RESET;
			else begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					flen = $urandom_range(1, 90);
				else if (pick < 7)
					flen = $urandom;
				else if (pick < 9)
					flen = FILE_LENGTH_RESET - $urandom_range(0, 3);
				else
					flen = '0;
			end
			load_file_length(flen);
			if (phase_no == 2)
				hold_req = 1'b1;
			repeat (6) begin
				if (sb.sent_items < ITEM_TARGET) begin
					calm = (sb.sent_items > ITEM_TARGET - 150);
					build_random(fb);
					send_file(fb);
				end
			end
			phase_no++;
		end

		byte_valid <= 1'b0;
		while (sb.results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
